@@ rtl/core/tedc_pkg.sv @@
// Shared types, constants and the microcode table of the touch calibration block.
// Used by tedc_div, touch_event_debounce_calibrate and tests; no dependencies.
`default_nettype none

package tedc_pkg;

    // Widths of samples, stored coefficients and multiplier operands.
    localparam int SAMPLE_BITS = 12;
    localparam int COEF_BITS   = 48;
    localparam int OP_BITS     = 28;
    localparam int QUOT_BITS   = 16;

    // Touch event codes.
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DOWN = 2'd1;
    localparam logic [1:0] EV_HOLD = 2'd2;
    localparam logic [1:0] EV_UP   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_MARGIN   = 2'd2;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd3;

    // Calibration phases: 1, 3 and 5 wait for a release, 2, 4 and 6 for a press.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_WAIT1  = 3'd2;
    localparam logic [2:0] PH_REL2   = 3'd3;
    localparam logic [2:0] PH_WAIT2  = 3'd4;
    localparam logic [2:0] PH_REL3   = 3'd5;
    localparam logic [2:0] PH_WAIT3  = 3'd6;
    localparam logic [2:0] PH_SOLVE  = 3'd7;

    // Coefficient slots.
    localparam logic [2:0] CI_A = 3'd0;
    localparam logic [2:0] CI_B = 3'd1;
    localparam logic [2:0] CI_C = 3'd2;
    localparam logic [2:0] CI_D = 3'd3;
    localparam logic [2:0] CI_E = 3'd4;
    localparam logic [2:0] CI_F = 3'd5;
    localparam logic [2:0] CI_K = 3'd6;
    localparam int         COEF_COUNT = 7;

    // Operand selects of the shared multiplier.
    localparam logic [4:0] OP_DX1 = 5'd0;
    localparam logic [4:0] OP_DX2 = 5'd1;
    localparam logic [4:0] OP_DY1 = 5'd2;
    localparam logic [4:0] OP_DY2 = 5'd3;
    localparam logic [4:0] OP_DU1 = 5'd4;
    localparam logic [4:0] OP_DU2 = 5'd5;
    localparam logic [4:0] OP_DV1 = 5'd6;
    localparam logic [4:0] OP_DV2 = 5'd7;
    localparam logic [4:0] OP_X1  = 5'd8;
    localparam logic [4:0] OP_X2  = 5'd9;
    localparam logic [4:0] OP_X3  = 5'd10;
    localparam logic [4:0] OP_Y1  = 5'd11;
    localparam logic [4:0] OP_Y2  = 5'd12;
    localparam logic [4:0] OP_Y3  = 5'd13;
    localparam logic [4:0] OP_U1  = 5'd14;
    localparam logic [4:0] OP_U2  = 5'd15;
    localparam logic [4:0] OP_U3  = 5'd16;
    localparam logic [4:0] OP_V1  = 5'd17;
    localparam logic [4:0] OP_V2  = 5'd18;
    localparam logic [4:0] OP_V3  = 5'd19;
    localparam logic [4:0] OP_TMP = 5'd20;
    localparam logic [4:0] OP_RX  = 5'd21;
    localparam logic [4:0] OP_RY  = 5'd22;
    localparam logic [4:0] OP_CA  = 5'd23;
    localparam logic [4:0] OP_CB  = 5'd24;
    localparam logic [4:0] OP_CD  = 5'd25;
    localparam logic [4:0] OP_CE  = 5'd26;
    localparam int         OP_COUNT = 27;

    // Microcode entry points.
    localparam logic [5:0] STEP_SOLVE = 6'd0;
    localparam logic [5:0] STEP_MAP   = 6'd28;
    localparam logic [5:0] STEP_MAP_X = 6'd30;

    // One microcode word.
    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       to_tmp;  // accumulate into the temporary register
        logic       neg;     // subtract the term
        logic       clr;     // start a new sum with this term
        logic       addc;    // the term is coefficient ci, not a product
        logic       store;   // write the new sum to coefficient ci
        logic [2:0] ci;
        logic       div;     // divide the sum by K after this step
        logic       last;
    } t_uop;

    function automatic t_uop mk(input logic [4:0] a, input logic [4:0] b,
                                input logic tmp, input logic neg, input logic clr,
                                input logic addc, input logic store,
                                input logic [2:0] ci, input logic dv,
                                input logic last);
        t_uop u;
        u.a_sel  = a;
        u.b_sel  = b;
        u.to_tmp = tmp;
        u.neg    = neg;
        u.clr    = clr;
        u.addc   = addc;
        u.store  = store;
        u.ci     = ci;
        u.div    = dv;
        u.last   = last;
        return u;
    endfunction

    // Solve (steps 0 to 27) and mapping (steps 28 to 33) programs.
    function automatic t_uop step_uop(input logic [5:0] s);
        t_uop u;
        case (s)
            6'd0:  u = mk(OP_DX1, OP_DY2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_K, 1'b0, 1'b0);
            6'd1:  u = mk(OP_DX2, OP_DY1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, CI_K, 1'b0, 1'b0);
            6'd2:  u = mk(OP_DU1, OP_DY2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_A, 1'b0, 1'b0);
            6'd3:  u = mk(OP_DU2, OP_DY1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, CI_A, 1'b0, 1'b0);
            6'd4:  u = mk(OP_DX1, OP_DU2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_B, 1'b0, 1'b0);
            6'd5:  u = mk(OP_DU1, OP_DX2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, CI_B, 1'b0, 1'b0);
            6'd6:  u = mk(OP_DV1, OP_DY2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_D, 1'b0, 1'b0);
            6'd7:  u = mk(OP_DV2, OP_DY1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, CI_D, 1'b0, 1'b0);
            6'd8:  u = mk(OP_DX1, OP_DV2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_E, 1'b0, 1'b0);
            6'd9:  u = mk(OP_DV1, OP_DX2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, CI_E, 1'b0, 1'b0);
            6'd10: u = mk(OP_X3,  OP_U2,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd11: u = mk(OP_X2,  OP_U3,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd12: u = mk(OP_Y1,  OP_TMP, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd13: u = mk(OP_X1,  OP_U3,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd14: u = mk(OP_X3,  OP_U1,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd15: u = mk(OP_Y2,  OP_TMP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd16: u = mk(OP_X2,  OP_U1,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd17: u = mk(OP_X1,  OP_U2,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd18: u = mk(OP_Y3,  OP_TMP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, CI_C, 1'b0, 1'b0);
            6'd19: u = mk(OP_X3,  OP_V2,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd20: u = mk(OP_X2,  OP_V3,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd21: u = mk(OP_Y1,  OP_TMP, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd22: u = mk(OP_X1,  OP_V3,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd23: u = mk(OP_X3,  OP_V1,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd24: u = mk(OP_Y2,  OP_TMP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd25: u = mk(OP_X2,  OP_V1,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd26: u = mk(OP_X1,  OP_V2,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd27: u = mk(OP_Y3,  OP_TMP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, CI_F, 1'b0, 1'b1);
            6'd28: u = mk(OP_CA,  OP_RX,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd29: u = mk(OP_CB,  OP_RY,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CI_C, 1'b0, 1'b0);
            6'd30: u = mk(OP_CA,  OP_RX,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, CI_C, 1'b1, 1'b0);
            6'd31: u = mk(OP_CD,  OP_RX,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd32: u = mk(OP_CE,  OP_RY,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CI_F, 1'b0, 1'b0);
            6'd33: u = mk(OP_CD,  OP_RX,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, CI_F, 1'b1, 1'b1);
            default: u = mk(OP_DX1, OP_DX1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CI_A, 1'b0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tedc_div.sv @@
// Bit-serial divider for the coordinate mapping: quotient truncated toward zero,
// clamped to 0..65535, zero for a zero divisor. Depends on tedc_pkg.
`default_nettype none

module tedc_div
    import tedc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [COEF_BITS-1:0] i_num,
    input  wire logic signed [COEF_BITS-1:0] i_den,
    output logic                             o_done,
    output logic [QUOT_BITS-1:0]             o_quot
);

    localparam int SH_BITS = COEF_BITS + QUOT_BITS;

    logic                    r_busy;
    logic                    r_done;
    logic [3:0]              r_cnt;
    logic [COEF_BITS-1:0]    r_rem;
    logic [SH_BITS-1:0]      r_dsh;
    logic [QUOT_BITS-1:0]    r_quot;

    logic [COEF_BITS-1:0]    w_abs_num;
    logic [COEF_BITS-1:0]    w_abs_den;
    logic                    w_zero;
    logic                    w_over;
    logic                    w_ge;

    // Magnitudes and the cases that need no iteration.
    always_comb begin
        w_abs_num = i_num[COEF_BITS-1] ? COEF_BITS'(-i_num) : COEF_BITS'(i_num);
        w_abs_den = i_den[COEF_BITS-1] ? COEF_BITS'(-i_den) : COEF_BITS'(i_den);
        w_zero    = (i_den == '0) || (i_num == '0)
                    || (i_num[COEF_BITS-1] != i_den[COEF_BITS-1]);
        w_over    = {{QUOT_BITS{1'b0}}, w_abs_num} >= {w_abs_den, {QUOT_BITS{1'b0}}};
        w_ge      = {{QUOT_BITS{1'b0}}, r_rem} >= r_dsh;
    end

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_zero) begin
                    r_quot <= '0;
                    r_done <= 1'b1;
                end else if (w_over) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_abs_num;
                    r_dsh  <= SH_BITS'({w_abs_den, {(QUOT_BITS-1){1'b0}}});
                    r_quot <= '0;
                    r_cnt  <= 4'(QUOT_BITS - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[COEF_BITS-1:0];
                end
                r_quot <= {r_quot[QUOT_BITS-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ rtl/core/touch_event_debounce_calibrate.sv @@
// Touch panel front end: debounce, three-point calibration and coordinate mapping.
// Depends on tedc_pkg and tedc_div.
//
// One input word gives one result word. A word is taken only while the block
// is idle; its handling is sequenced over one shared 28x28 multiplier with an
// accumulator and a one-bit-per-cycle divider. A start command or a tick that
// neither maps nor solves goes from classification straight to the output
// state; a mapped press is classified, then per axis runs three multiply steps
// and a division, which needs no iteration when the quotient is zero or clamps,
// then reaches the output state; the tick that completes the third capture runs
// the 28-step solve program. The block stays busy while a finished result waits
// for the previous word to be taken.
`default_nettype none

module touch_event_debounce_calibrate
    import tedc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    // Input words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // pen_down[0], raw_x[12:1], raw_y[24:13]
    input  wire logic        s_axis_tuser,  // kind[0]
    // Result words.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // event_res[1:0], pressed[2], screen_x[18:3],
                                            // screen_y[34:19], calib_phase[37:35],
                                            // calib_valid[38]
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // Configuration.
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [7:0]  r_margin;
    logic [7:0]  r_debounce;

    // Control state.
    logic [2:0]  r_state;
    logic [5:0]  r_step;
    logic        r_div_go;
    logic        r_m_valid;
    logic [39:0] r_m_data;
    logic [7:0]  r_cnt;
    logic [1:0]  r_ev;
    logic        r_press;
    logic [2:0]  r_phase;
    logic        r_cvalid;
    logic signed [COEF_BITS-1:0] r_coef [COEF_COUNT];
    logic [QUOT_BITS-1:0] r_pos_x;
    logic [QUOT_BITS-1:0] r_pos_y;

    // Payload registers.
    logic                          r_kind;
    logic                          r_pen;
    logic [SAMPLE_BITS-1:0]        r_rx;
    logic [SAMPLE_BITS-1:0]        r_ry;
    logic [SAMPLE_BITS-1:0]        r_px1, r_py1, r_px2, r_py2, r_px3, r_py3;
    logic signed [COEF_BITS-1:0]   r_acc;
    logic signed [OP_BITS-1:0]     r_tmp;

    // Debounce next values.
    logic [7:0]  n_cnt;
    logic [1:0]  n_ev;
    logic        n_press;
    logic [2:0]  n_phase;
    logic        n_cap;
    logic        n_map;
    logic        n_solve;
    logic [7:0]  w_cnt_inc;
    logic [2:0]  w_ph;

    // Datapath.
    t_uop                          w_uop;
    logic signed [OP_BITS-1:0]     w_ops [OP_COUNT];
    logic signed [OP_BITS-1:0]     w_a;
    logic signed [OP_BITS-1:0]     w_b;
    logic signed [2*OP_BITS-1:0]   w_prod;
    logic signed [COEF_BITS-1:0]   w_term;
    logic signed [COEF_BITS-1:0]   n_acc;
    logic signed [OP_BITS-1:0]     n_tmp;
    logic signed [OP_BITS-1:0]     w_u1, w_u23, w_v12, w_v3;
    logic                          w_div_done;
    logic [QUOT_BITS-1:0]          w_quot;

    logic w_in_acc;
    logic w_out_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = r_m_valid && m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 12'd576;
            r_height   <= 12'd480;
            r_margin   <= 8'd40;
            r_debounce <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:    r_width    <= i_cfg_data;
                CFG_HEIGHT:   r_height   <= i_cfg_data;
                CFG_MARGIN:   r_margin   <= i_cfg_data[7:0];
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Debounce classification followed by the calibration sequencer.
    always_comb begin
        w_cnt_inc = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
        n_cnt     = r_cnt;
        n_ev      = r_ev;
        n_press   = r_press;
        n_phase   = r_phase;
        n_cap     = 1'b0;
        n_map     = 1'b0;
        n_solve   = 1'b0;
        w_ph      = r_phase;
        if (r_kind) begin
            n_phase = PH_START;
        end else begin
            if (r_pen) begin
                n_cnt = w_cnt_inc;
                if (r_cnt >= r_debounce) begin
                    n_ev = (r_ev == EV_NONE) ? EV_DOWN : EV_HOLD;
                    if (r_phase != PH_IDLE) begin
                        if (w_cnt_inc > r_debounce) begin
                            if (r_phase == PH_WAIT1 || r_phase == PH_WAIT2
                                || r_phase == PH_WAIT3) begin
                                n_cap   = 1'b1;
                                n_phase = r_phase + 3'd1;
                            end
                        end else begin
                            n_press = 1'b1;
                        end
                    end else begin
                        n_map   = 1'b1;
                        n_press = 1'b1;
                    end
                end
            end else if (r_ev == EV_DOWN || r_ev == EV_HOLD) begin
                n_ev  = EV_UP;
                n_cnt = w_cnt_inc;
            end else if (r_ev == EV_UP) begin
                if (r_cnt >= r_debounce) begin
                    n_ev  = EV_NONE;
                    n_cnt = 8'd0;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end else begin
                n_ev    = EV_NONE;
                n_press = 1'b0;
                n_cnt   = 8'd0;
            end
            // Sequencer: odd phases wait for a full release, the last one solves.
            w_ph = n_phase;
            if (w_ph == PH_START || w_ph == PH_REL2 || w_ph == PH_REL3) begin
                if (n_cnt == 8'd0) begin
                    n_phase = w_ph + 3'd1;
                end
            end else if (w_ph == PH_SOLVE) begin
                n_solve = 1'b1;
                n_phase = PH_IDLE;
            end
        end
    end

    // Calibration targets as signed operands.
    always_comb begin
        w_u1  = OP_BITS'(r_margin);
        w_u23 = OP_BITS'(r_width) - OP_BITS'(r_margin);
        w_v12 = OP_BITS'(r_margin);
        w_v3  = OP_BITS'(r_height) - OP_BITS'(r_margin);
    end

    // Operand sources of the shared multiplier.
    always_comb begin
        w_ops[OP_DX1] = OP_BITS'(r_px1) - OP_BITS'(r_px3);
        w_ops[OP_DX2] = OP_BITS'(r_px2) - OP_BITS'(r_px3);
        w_ops[OP_DY1] = OP_BITS'(r_py1) - OP_BITS'(r_py3);
        w_ops[OP_DY2] = OP_BITS'(r_py2) - OP_BITS'(r_py3);
        w_ops[OP_DU1] = w_u1 - w_u23;
        w_ops[OP_DU2] = w_u23 - w_u23;
        w_ops[OP_DV1] = w_v12 - w_v3;
        w_ops[OP_DV2] = w_v12 - w_v3;
        w_ops[OP_X1]  = OP_BITS'(r_px1);
        w_ops[OP_X2]  = OP_BITS'(r_px2);
        w_ops[OP_X3]  = OP_BITS'(r_px3);
        w_ops[OP_Y1]  = OP_BITS'(r_py1);
        w_ops[OP_Y2]  = OP_BITS'(r_py2);
        w_ops[OP_Y3]  = OP_BITS'(r_py3);
        w_ops[OP_U1]  = w_u1;
        w_ops[OP_U2]  = w_u23;
        w_ops[OP_U3]  = w_u23;
        w_ops[OP_V1]  = w_v12;
        w_ops[OP_V2]  = w_v12;
        w_ops[OP_V3]  = w_v3;
        w_ops[OP_TMP] = r_tmp;
        w_ops[OP_RX]  = OP_BITS'(r_rx);
        w_ops[OP_RY]  = OP_BITS'(r_ry);
        w_ops[OP_CA]  = r_coef[CI_A][OP_BITS-1:0];
        w_ops[OP_CB]  = r_coef[CI_B][OP_BITS-1:0];
        w_ops[OP_CD]  = r_coef[CI_D][OP_BITS-1:0];
        w_ops[OP_CE]  = r_coef[CI_E][OP_BITS-1:0];
    end

    // Add or subtract the product or a coefficient into the accumulator or temporary.
    always_comb begin
        w_uop  = step_uop(r_step);
        w_a    = w_ops[w_uop.a_sel];
        w_b    = w_ops[w_uop.b_sel];
        w_prod = w_a * w_b;
        w_term = w_uop.addc ? r_coef[w_uop.ci] : w_prod[COEF_BITS-1:0];
        if (w_uop.neg) begin
            w_term = -w_term;
        end
        n_acc = w_uop.clr ? w_term : r_acc + w_term;
        n_tmp = w_uop.clr ? w_term[OP_BITS-1:0] : r_tmp + w_term[OP_BITS-1:0];
    end

    tedc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_acc),
        .i_den   (r_coef[CI_K]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Payload registers: input word, captured points, sums.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= s_axis_tuser;
            r_pen  <= s_axis_tdata[0];
            r_rx   <= s_axis_tdata[12:1];
            r_ry   <= s_axis_tdata[24:13];
        end
        if (r_state == ST_EXEC && n_cap) begin
            case (r_phase)
                PH_WAIT1: begin
                    r_px1 <= r_rx;
                    r_py1 <= r_ry;
                end
                PH_WAIT2: begin
                    r_px2 <= r_rx;
                    r_py2 <= r_ry;
                end
                default: begin
                    r_px3 <= r_rx;
                    r_py3 <= r_ry;
                end
            endcase
        end
        if (r_state == ST_STEP) begin
            if (w_uop.to_tmp) begin
                r_tmp <= n_tmp;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= STEP_SOLVE;
            r_div_go  <= 1'b0;
            r_m_valid <= 1'b0;
            r_cnt     <= 8'd0;
            r_ev      <= EV_NONE;
            r_press   <= 1'b0;
            r_phase   <= PH_IDLE;
            r_cvalid  <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            for (int i = 0; i < COEF_COUNT; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_div_go <= 1'b0;
            // The output state reloads the result register itself.
            if (w_out_acc && r_state != ST_OUT) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_cnt   <= n_cnt;
                    r_ev    <= n_ev;
                    r_press <= n_press;
                    r_phase <= n_phase;
                    if (n_solve) begin
                        r_cvalid <= 1'b1;
                        r_step   <= STEP_SOLVE;
                        r_state  <= ST_STEP;
                    end else if (n_map) begin
                        r_step  <= STEP_MAP;
                        r_state <= ST_STEP;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_STEP: begin
                    if (w_uop.store) begin
                        r_coef[w_uop.ci] <= n_acc;
                    end
                    if (w_uop.div) begin
                        r_div_go <= 1'b1;
                        r_state  <= ST_DIV;
                    end else if (w_uop.last) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (r_step == STEP_MAP_X) begin
                            r_pos_x <= w_quot;
                        end else begin
                            r_pos_y <= w_quot;
                        end
                        if (w_uop.last) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_step  <= r_step + 6'd1;
                            r_state <= ST_STEP;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {1'b0, r_cvalid, r_phase, r_pos_y, r_pos_x,
                                      r_press, r_ev};
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ test/touch_cal_checker.sv @@
// Checker for the touch calibration block: watches both word channels, predicts results.
// Depends on tedc_pkg; instantiated by the testbench top beside the block.
module touch_cal_checker
    import tedc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        calib_valid;
        logic [2:0]  calib_phase;
        logic [15:0] screen_y;
        logic [15:0] screen_x;
        logic        pressed;
        logic [1:0]  event_res;
    } touch_result_t;

    // Shadow of the configuration registers.
    logic [11:0] width_q, height_q;
    logic [7:0]  margin_q, debounce_q;

    // Shadow of the block state.
    logic [7:0]         hold_cnt;
    logic [1:0]         ev_state;
    logic               press_q;
    logic [2:0]         phase_q;
    logic [11:0]        points[6];
    longint             coef[7];
    logic               coef_ok;
    logic [15:0]        pos_x, pos_y;
    touch_result_t      expected_results[$];

    function automatic longint sat48(input longint v);
        longint hi;
        hi = (longint'(1) <<< (COEF_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic logic [15:0] map_coord(input longint p, input longint q, input longint r,
                                              input longint x, input longint y);
        longint v;
        if (coef[CI_K] == 0) return 16'd0;
        v = (p * x + q * y + r) / coef[CI_K];
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    // Solve the seven transform coefficients from the captured points.
    task automatic solve_coefficients();
        longint x1, y1, x2, y2, x3, y3, m, u1, u2, u3, v1, v2, v3;
        x1 = points[0]; y1 = points[1]; x2 = points[2];
        y2 = points[3]; x3 = points[4]; y3 = points[5];
        m = margin_q;
        u1 = m; u2 = longint'(width_q) - m; u3 = u2;
        v1 = m; v2 = m; v3 = longint'(height_q) - m;
        coef[CI_K] = sat48((x1 - x3) * (y2 - y3) - (x2 - x3) * (y1 - y3));
        coef[CI_A] = sat48((u1 - u3) * (y2 - y3) - (u2 - u3) * (y1 - y3));
        coef[CI_B] = sat48((x1 - x3) * (u2 - u3) - (u1 - u3) * (x2 - x3));
        coef[CI_C] = sat48(y1 * (x3 * u2 - x2 * u3) + y2 * (x1 * u3 - x3 * u1)
                           + y3 * (x2 * u1 - x1 * u2));
        coef[CI_D] = sat48((v1 - v3) * (y2 - y3) - (v2 - v3) * (y1 - y3));
        coef[CI_E] = sat48((x1 - x3) * (v2 - v3) - (v1 - v3) * (x2 - x3));
        coef[CI_F] = sat48(y1 * (x3 * v2 - x2 * v3) + y2 * (x1 * v3 - x3 * v1)
                           + y3 * (x2 * v1 - x1 * v2));
        coef_ok = 1'b1;
        phase_q = PH_IDLE;
    endtask

    // Debounce one tick, including capture and mapping of a held press.
    task automatic debounce_tick(input logic pen, input logic [11:0] rx, input logic [11:0] ry);
        logic [2:0] ph;
        if (pen) begin
            if (hold_cnt >= debounce_q) begin
                ev_state = (ev_state == EV_NONE) ? EV_DOWN : EV_HOLD;
                hold_cnt = bump(hold_cnt);
                if (phase_q != PH_IDLE) begin
                    if (hold_cnt > debounce_q) begin
                        ph = phase_q;
                        if (ph == PH_WAIT1 || ph == PH_WAIT2 || ph == PH_WAIT3) begin
                            points[ph - 3'd2] = rx;
                            points[ph - 3'd1] = ry;
                            phase_q = ph + 3'd1;
                        end
                        return;
                    end
                end else begin
                    pos_x = map_coord(coef[CI_A], coef[CI_B], coef[CI_C], rx, ry);
                    pos_y = map_coord(coef[CI_D], coef[CI_E], coef[CI_F], rx, ry);
                end
                press_q = 1'b1;
            end else begin
                hold_cnt = bump(hold_cnt);
            end
        end else if (ev_state == EV_DOWN || ev_state == EV_HOLD) begin
            ev_state = EV_UP;
            hold_cnt = bump(hold_cnt);
        end else if (ev_state == EV_UP) begin
            if (hold_cnt >= debounce_q) begin
                ev_state = EV_NONE;
                hold_cnt = 8'd0;
            end else begin
                hold_cnt = bump(hold_cnt);
            end
        end else begin
            press_q = 1'b0;
            hold_cnt = 8'd0;
        end
    endtask

    // Predict the result of one accepted input word.
    task automatic predict_touch(input logic start, input logic [31:0] d);
        touch_result_t r;
        if (start) begin
            phase_q = PH_START;
        end else begin
            debounce_tick(d[0], d[12:1], d[24:13]);
            if (phase_q == PH_START || phase_q == PH_REL2 || phase_q == PH_REL3) begin
                if (hold_cnt == 8'd0) phase_q = phase_q + 3'd1;
            end else if (phase_q == PH_SOLVE) begin
                solve_coefficients();
            end
        end
        r.event_res = ev_state;
        r.pressed = press_q;
        r.screen_x = pos_x;
        r.screen_y = pos_y;
        r.calib_phase = phase_q;
        r.calib_valid = coef_ok;
        expected_results.push_back(r);
    endtask

    assign o_pending = expected_results.size();

    // Track configuration, predict on input words, compare on result words.
    always @(posedge i_clk) begin
        touch_result_t got, want;
        if (!i_rst_n) begin
            width_q <= 12'd576; height_q <= 12'd480;
            margin_q <= 8'd40; debounce_q <= 8'd5;
            hold_cnt <= '0; ev_state <= EV_NONE; press_q <= 1'b0;
            phase_q <= PH_IDLE; coef_ok <= 1'b0; pos_x <= '0; pos_y <= '0;
            for (int i = 0; i < COEF_COUNT; i++) coef[i] = 0;
            for (int i = 0; i < 6; i++) points[i] = '0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:    width_q = i_cfg_data;
                    CFG_HEIGHT:   height_q = i_cfg_data;
                    CFG_MARGIN:   margin_q = i_cfg_data[7:0];
                    CFG_DEBOUNCE: debounce_q = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) predict_touch(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[38:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected ev=%0d pr=%0d x=%0d y=%0d ph=%0d cv=%0d",
                                 $realtime, want.event_res, want.pressed, want.screen_x,
                                 want.screen_y, want.calib_phase, want.calib_valid);
                        $display("%0t:          actual   ev=%0d pr=%0d x=%0d y=%0d ph=%0d cv=%0d",
                                 $realtime, got.event_res, got.pressed, got.screen_x,
                                 got.screen_y, got.calib_phase, got.calib_valid);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/testbench.sv @@
// Top of the touch calibration testbench: clock, reset, stimulus and verdict.
// Depends on tedc_pkg, touch_event_debounce_calibrate and touch_cal_checker.
module testbench;
    import tedc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_WIDTH;
    logic [11:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    int          fail_count, pending;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    logic [11:0] seq_x, seq_y;
    int          hold_len;

    always #6 i_clk = ~i_clk;

    touch_event_debounce_calibrate dut (.*);

    touch_cal_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    // Run limit: the test fails if it does not finish in time.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: ready stalls in random bursts, none near the end.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Send one word, with an optional random gap before it. The word stays
    // driven after acceptance until the next word or an explicit stop.
    task automatic send_word(input logic start, input logic pen,
                             input logic [11:0] rx, input logic [11:0] ry);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= start;
        s_axis_tdata <= {7'd0, ry, rx, pen};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic tick(input logic pen);
        send_word(1'b0, pen, 12'($urandom), 12'($urandom));
    endtask

    // Write a register once all results are in and the block has settled.
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Full calibration: start, then three held presses separated by releases.
    task automatic calibrate(input int db, input bit extremes);
        send_word(1'b1, 1'b0, 12'd0, 12'd0);
        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < db + 3; i++) tick(1'b0);
            seq_x = extremes ? ((p == 1) ? 12'hFFF : 12'd0) : 12'($urandom);
            seq_y = extremes ? ((p == 2) ? 12'hFFF : 12'd0) : 12'($urandom);
            for (int i = 0; i < db + 2; i++) send_word(1'b0, 1'b1, seq_x, seq_y);
        end
        for (int i = 0; i < db + 3; i++) tick(1'b0);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: presses before calibration, a start, extreme captures.
        for (int i = 0; i < 8; i++) send_word(1'b0, 1'b1, 12'hFFF, 12'h000);
        for (int i = 0; i < 7; i++) send_word(1'b0, 1'b0, 12'h000, 12'hFFF);
        calibrate(5, 1'b1);
        for (int i = 0; i < 8; i++) send_word(1'b0, 1'b1, 12'hFFF, 12'hFFF);

        // Settings sweep, including the extremes and a margin past the screen.
        for (int phase_i = 0; phase_i < 6; phase_i++) begin
            case (phase_i)
                0: begin
                    write_reg(CFG_WIDTH, 12'd64); write_reg(CFG_HEIGHT, 12'd64);
                    write_reg(CFG_MARGIN, 12'd255); write_reg(CFG_DEBOUNCE, 12'd1);
                end
                1: begin
                    write_reg(CFG_WIDTH, 12'd4095); write_reg(CFG_HEIGHT, 12'd4095);
                    write_reg(CFG_MARGIN, 12'd0); write_reg(CFG_DEBOUNCE, 12'd0);
                end
                2: begin
                    write_reg(CFG_DEBOUNCE, 12'd255);
                    // Long hold to saturate the counter.
                    for (int i = 0; i < 300; i++) send_word(1'b0, 1'b1, 12'd100, 12'd200);
                    write_reg(CFG_DEBOUNCE, 12'd3);
                end
                default: begin
                    write_reg(CFG_WIDTH, 12'($urandom_range(64, 4095)));
                    write_reg(CFG_HEIGHT, 12'($urandom_range(64, 4095)));
                    write_reg(CFG_MARGIN, 12'($urandom_range(0, 255)));
                    write_reg(CFG_DEBOUNCE, 12'($urandom_range(1, 6)));
                end
            endcase
            hold_len = (phase_i == 2) ? 3 : 6;
            // Occasional calibration plus touch strokes, with random noise.
            for (int n = 0; n < 8; n++) begin
                if (phase_i == 5 && n == 5) quiet = 1'b1;
                if ($urandom_range(0, 3) == 0) calibrate(hold_len, 1'b0);
                for (int s = 0; s < 2; s++) begin
                    seq_x = 12'($urandom); seq_y = 12'($urandom);
                    for (int i = 0; i < $urandom_range(1, 12); i++)
                        send_word(1'b0, 1'b1, seq_x + 12'(i), seq_y - 12'(i));
                    for (int i = 0; i < $urandom_range(1, 10); i++) tick(1'b0);
                end
                for (int i = 0; i < 6; i++) begin
                    if ($urandom_range(0, 15) == 0) send_word(1'b1, 1'b0, '0, '0);
                    else tick($urandom_range(0, 1));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/tedc_pkg.sv
rtl/core/tedc_div.sv
rtl/core/touch_event_debounce_calibrate.sv
test/touch_cal_checker.sv
test/testbench.sv
